@@ hdl/csc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sample conditioner package
// Request types, stage payloads, configuration codes and fixed constants
// shared by the conditioner modules.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Fixed arithmetic widths.
  localparam int SUM_W   = 20;  // group sum width
  localparam int FRAC_W  = 4;   // fraction bits of the average
  localparam int AVG_W   = SUM_W + FRAC_W;
  localparam int CFG_W   = 20;  // widest configuration register
  localparam int THR_W   = 16;
  localparam int SCALE_FRAC_W = 16;  // fraction bits of the inverse scale
  localparam int MAG_W   = 15;  // magnitude bits of the current
  localparam int VOLT_W  = 13;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_OFFSET       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] FLOOR_OFFSET_RST       = 20'd4080;   // 255.0
  localparam logic [CFG_W-1:0] INVERSE_SCALE_RST      = 20'd20539;  // 1 / 3.1909
  localparam logic [THR_W-1:0] NEGATIVE_THRESHOLD_RST = 16'd500;

  typedef struct packed {
    logic [15:0] conversion;
    logic        raw_mode;
    logic        charge_pin;
    logic [9:0]  voltage_code;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic signed [15:0] current;
    logic [VOLT_W-1:0]  voltage;
    logic [31:0]        stamp_ms;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] floor_offset;
    logic [CFG_W-1:0] inverse_scale;
    logic [THR_W-1:0] negative_threshold;
  } cfg_t;

  // Completed group sum with the fields of the group's last word.
  typedef struct packed {
    logic [SUM_W-1:0]  total;
    logic              raw_mode;
    logic              charge_pin;
    logic [VOLT_W-1:0] voltage;
    logic [31:0]       stamp_ms;
  } sum_stage_t;

  // Group average, 20.4 fixed point.
  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic              raw_mode;
    logic              charge_pin;
    logic [VOLT_W-1:0] voltage;
    logic [31:0]       stamp_ms;
  } avg_stage_t;

  // Average after the floor, 20.4 fixed point.
  typedef struct packed {
    logic [AVG_W-1:0]  value;
    logic              raw_mode;
    logic              charge_pin;
    logic [VOLT_W-1:0] voltage;
    logic [31:0]       stamp_ms;
  } val_stage_t;

  // Unsaturated magnitude and sign filter enable.
  typedef struct packed {
    logic [AVG_W-1:0]  mag;
    logic              filter_en;
    logic [VOLT_W-1:0] voltage;
    logic [31:0]       stamp_ms;
  } mag_stage_t;

endpackage

@@ hdl/csc_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word accumulator
// Sums converter words and hands each completed group sum, with the fields
// of the group's last word, to the averaging stage.
// ----------------------------------------------------------------------------
module csc_accum
  import csc_pkg::*;
#(
  parameter int WORDS_PER_SAMPLE = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       st_valid,
  input  logic       st_ready,
  output sum_stage_t st_data
);

  localparam int CNT_W = (WORDS_PER_SAMPLE > 1) ? $clog2(WORDS_PER_SAMPLE) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORDS_PER_SAMPLE - 1);

  logic [SUM_W-1:0] sum_accumulator;
  logic [CNT_W-1:0] word_count;
  logic [SUM_W-1:0] total;
  logic             accept;
  logic             last_word;

  assign in_ready   = !st_valid || st_ready;
  assign accept     = in_valid && in_ready;
  // The sum wraps at its register width.
  assign total      = sum_accumulator + SUM_W'(in_data.conversion);
  assign last_word  = (word_count == LAST_CNT);

  // Running sum and word count.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_accumulator <= '0;
      word_count      <= '0;
    end else if (accept) begin
      if (last_word) begin
        sum_accumulator <= '0;
        word_count      <= '0;
      end else begin
        sum_accumulator <= total;
        word_count      <= word_count + 1'b1;
      end
    end
  end

  // Stage valid: set on a group's last word, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept && last_word) begin
      st_valid <= 1'b1;
    end else if (st_ready) begin
      st_valid <= 1'b0;
    end
  end

  // Stage payload; the voltage is the code times five.
  always_ff @(posedge clk) begin
    if (accept && last_word) begin
      st_data.total       <= total;
      st_data.raw_mode    <= in_data.raw_mode;
      st_data.charge_pin  <= in_data.charge_pin;
      st_data.voltage     <= VOLT_W'({in_data.voltage_code, 2'b00})
                             + VOLT_W'(in_data.voltage_code);
      st_data.stamp_ms    <= in_data.time_ms;
    end
  end

endmodule

@@ hdl/csc_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group average
// Divides the group sum by the group length with 4 fraction bits, using a
// multiplication by a rounded-up reciprocal that is exact over the sum range.
// ----------------------------------------------------------------------------
module csc_average
  import csc_pkg::*;
#(
  parameter int WORDS_PER_SAMPLE = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  sum_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output avg_stage_t dn_data
);

  // Shift large enough that the reciprocal error never reaches one step.
  localparam int LOG_W     = $clog2(WORDS_PER_SAMPLE);
  localparam int DIV_SHIFT = AVG_W + LOG_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam longint RECIP_FULL =
    ((64'sd1 <<< DIV_SHIFT) + WORDS_PER_SAMPLE - 1) / WORDS_PER_SAMPLE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int AVG_LSB   = DIV_SHIFT - FRAC_W;

  logic [PROD_W-1:0] product;
  logic              load;

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;
  assign product  = PROD_W'(up_data.total) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  // Average = sum * 16 / words, truncated.
  always_ff @(posedge clk) begin
    if (load) begin
      dn_data.avg         <= product[AVG_LSB +: AVG_W];
      dn_data.raw_mode    <= up_data.raw_mode;
      dn_data.charge_pin  <= up_data.charge_pin;
      dn_data.voltage     <= up_data.voltage;
      dn_data.stamp_ms    <= up_data.stamp_ms;
    end
  end

endmodule

@@ hdl/csc_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor and scale
// Removes the calibration floor (clamped at zero) and multiplies by the
// inverse scale in normal mode; passes the average through in raw mode.
// Two register stages: floor, then multiply.
// ----------------------------------------------------------------------------
module csc_scale
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       up_valid,
  output logic       up_ready,
  input  avg_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output mag_stage_t dn_data
);

  localparam int PROD_W = AVG_W + CFG_W;
  localparam int SCALE_LSB = SCALE_FRAC_W + FRAC_W;

  logic              val_valid;
  logic              val_ready;
  val_stage_t        val_data;
  logic              val_load;
  logic              mag_load;
  logic [AVG_W-1:0]  floor_ext;
  logic [AVG_W-1:0]  value_next;
  logic [PROD_W-1:0] product;
  logic [AVG_W-1:0]  thr_ext;

  assign up_ready  = !val_valid || val_ready;
  assign val_load  = up_valid && up_ready;
  assign val_ready = !dn_valid || dn_ready;
  assign mag_load  = val_valid && val_ready;

  // Floor subtraction with clamp at zero.
  assign floor_ext = AVG_W'(cfg.floor_offset);
  always_comb begin
    if (up_data.raw_mode) begin
      value_next = up_data.avg;
    end else if (up_data.avg > floor_ext) begin
      value_next = up_data.avg - floor_ext;
    end else begin
      value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_valid <= 1'b0;
    end else if (val_load) begin
      val_valid <= 1'b1;
    end else if (val_ready) begin
      val_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (val_load) begin
      val_data.value       <= value_next;
      val_data.raw_mode    <= up_data.raw_mode;
      val_data.charge_pin  <= up_data.charge_pin;
      val_data.voltage     <= up_data.voltage;
      val_data.stamp_ms    <= up_data.stamp_ms;
    end
  end

  // Scale multiply and threshold compare on the floored value.
  assign product = PROD_W'(val_data.value) * PROD_W'(cfg.inverse_scale);
  assign thr_ext = AVG_W'({cfg.negative_threshold, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (mag_load) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_load) begin
      if (val_data.raw_mode) begin
        dn_data.mag <= AVG_W'(val_data.value[AVG_W-1:FRAC_W]);
      end else begin
        dn_data.mag <= product[SCALE_LSB +: AVG_W];
      end
      dn_data.filter_en <= !val_data.charge_pin && (val_data.value > thr_ext);
      dn_data.voltage   <= val_data.voltage;
      dn_data.stamp_ms  <= val_data.stamp_ms;
    end
  end

endmodule

@@ hdl/csc_output.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign filter and result register
// Saturates the magnitude, applies the sign filter against the previous
// reading and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module csc_output
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  mag_stage_t up_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  logic             last_was_negative;
  logic             last_was_negative_next;
  logic [MAG_W-1:0] mag_sat;
  logic [15:0]      mag_ext;
  logic [15:0]      current_next;
  logic             load;

  assign up_ready = !out_valid || out_ready;
  assign load     = up_valid && up_ready;

  // Saturate at the largest positive current.
  assign mag_sat = (up_data.mag > AVG_W'(MAG_MAX)) ? MAG_MAX : up_data.mag[MAG_W-1:0];
  assign mag_ext = {1'b0, mag_sat};

  // Negate only when the previous filtered reading was marked negative.
  always_comb begin
    if (up_data.filter_en) begin
      current_next           = last_was_negative ? (16'd0 - mag_ext) : mag_ext;
      last_was_negative_next = (mag_sat != '0);
    end else begin
      current_next           = mag_ext;
      last_was_negative_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      last_was_negative <= 1'b0;
    end else begin
      if (load) begin
        out_valid         <= 1'b1;
        last_was_negative <= last_was_negative_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.current  <= signed'(current_next);
      out_data.voltage  <= up_data.voltage;
      out_data.stamp_ms <= up_data.stamp_ms;
    end
  end

endmodule

@@ hdl/current_sample_conditioner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sample conditioner
// Averages groups of ammeter converter words and turns each group into one
// calibrated, sign-filtered current reading with voltage and timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_ready carry one converter word per request, with the mode,
//   charge flag, voltage code and timestamp that count on a group's last word.
//   Every WORDS_PER_SAMPLE-th word closes a group and yields one result
//   request on out_valid / out_ready; other words yield none.
//   cfg_write_en writes cfg_data to register cfg_index: 0 is the
//   floor offset, 1 the inverse scale, 2 the negative threshold. Write only
//   while no group result is pending.
//   Throughput: one word per cycle while in_ready is high. A group's last
//   word passes through the sum, average, floor and scale multiply
//   registers, then the result register, before its result appears.
//   When the receiver stalls, the result register holds and each stage fills
//   in turn; in_ready falls only once every stage holds a result.
//   Reset clears the group sum, word count, sign history and all stage
//   valids, and loads the calibration registers with their defaults.
// ----------------------------------------------------------------------------
module current_sample_conditioner_top
  import csc_pkg::*;
#(
  parameter int WORDS_PER_SAMPLE = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg;
  logic       sum_valid;
  logic       sum_ready;
  sum_stage_t sum_data;
  logic       avg_valid;
  logic       avg_ready;
  avg_stage_t avg_data;
  logic       mag_valid;
  logic       mag_ready;
  mag_stage_t mag_data;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_offset       <= FLOOR_OFFSET_RST;
      cfg.inverse_scale      <= INVERSE_SCALE_RST;
      cfg.negative_threshold <= NEGATIVE_THRESHOLD_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FLOOR_OFFSET:       cfg.floor_offset       <= cfg_data;
        CFG_INVERSE_SCALE:      cfg.inverse_scale      <= cfg_data;
        CFG_NEGATIVE_THRESHOLD: cfg.negative_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  csc_accum #(
    .WORDS_PER_SAMPLE(WORDS_PER_SAMPLE)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .st_valid (sum_valid),
    .st_ready (sum_ready),
    .st_data  (sum_data)
  );

  csc_average #(
    .WORDS_PER_SAMPLE(WORDS_PER_SAMPLE)
  ) u_average (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (avg_valid),
    .dn_ready (avg_ready),
    .dn_data  (avg_data)
  );

  csc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (avg_valid),
    .up_ready (avg_ready),
    .up_data  (avg_data),
    .dn_valid (mag_valid),
    .dn_ready (mag_ready),
    .dn_data  (mag_data)
  );

  csc_output u_output (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (mag_valid),
    .up_ready  (mag_ready),
    .up_data   (mag_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/csc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sample conditioner checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
module csc_checker
  import csc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result request holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // The magnitude saturates, so the most negative code never appears.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.current != 16'sh8000)
    else $error("current outside the saturated range");

  // Voltage is at most five times the largest code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.voltage <= 13'd5115)
    else $error("voltage outside its range");

endmodule

bind current_sample_conditioner_top csc_checker u_csc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sample conditioner testbench
// Sends converter words in groups, predicts each group's filtered current,
// voltage and timestamp, and checks every result request field by field.
// A short table of directed groups runs first, then several calibration
// phases of random words with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import csc_pkg::*;

  localparam int GROUP_WORDS    = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 222;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // One directed group: every word of the group carries the same fields.
  typedef struct packed {
    logic [15:0]       word;
    logic              raw;
    logic              charge;
    logic [9:0]        vcode;
    logic [31:0]       stamp;
    logic              typed;
    logic [15:0]       current;
    logic [VOLT_W-1:0] volt;
  } group_row_t;

  // One calibration phase; draw picks random register values instead.
  typedef struct packed {
    logic [CFG_W-1:0] floor_ofs;
    logic [CFG_W-1:0] scale;
    logic [THR_W-1:0] threshold;
    logic             draw;
    logic [7:0]       gap_odds;
    logic [7:0]       stall_odds;
  } cal_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FLOOR_OFFSET;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state and its copy of the calibration registers.
  logic [CFG_W-1:0] cal_floor     = FLOOR_OFFSET_RST;
  logic [CFG_W-1:0] cal_scale     = INVERSE_SCALE_RST;
  logic [THR_W-1:0] cal_threshold = NEGATIVE_THRESHOLD_RST;
  logic [19:0]      acc_sum       = '0;
  logic [3:0]       acc_count     = '0;
  logic             prev_negative = 1'b0;

  out_t expected_readings[$];
  bit   failed = 1'b0;
  int   sender_gap_odds = 0;
  int   receiver_stall_odds = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  // Directed groups under the reset calibration.
  group_row_t directed_groups [10] = '{
    // All zero words in raw mode.
    '{16'd0,     1'b1, 1'b1, 10'd0,    32'h0000_0000, 1'b1, 16'd0,     13'd0},
    // Full-scale words in raw mode saturate, with the largest voltage code.
    '{16'hFFFF,  1'b1, 1'b1, 10'd1023, 32'hFFFF_FFFF, 1'b1, 16'd32767, 13'd5115},
    // Full-scale words through floor and scale.
    '{16'hFFFF,  1'b0, 1'b1, 10'd341,  32'h0000_0001, 1'b0, 16'd0,     13'd0},
    // Average under the floor clamps to zero.
    '{16'd200,   1'b0, 1'b0, 10'd512,  32'h8000_0000, 1'b1, 16'd0,     13'd2560},
    // Above the threshold with charge low: first positive, then negated.
    '{16'd20000, 1'b0, 1'b0, 10'd100,  32'h1234_5678, 1'b0, 16'd0,     13'd0},
    '{16'd20000, 1'b0, 1'b0, 10'd101,  32'h1234_5682, 1'b0, 16'd0,     13'd0},
    // Charge high clears the sign history.
    '{16'd20000, 1'b0, 1'b1, 10'd102,  32'h1234_568C, 1'b0, 16'd0,     13'd0},
    '{16'd20000, 1'b0, 1'b0, 10'd103,  32'h1234_5696, 1'b0, 16'd0,     13'd0},
    // Raw mode negated and saturated.
    '{16'd40000, 1'b1, 1'b0, 10'd200,  32'hDEAD_0000, 1'b1, 16'h8001,  13'd1000},
    // Below the threshold: positive, history cleared.
    '{16'd300,   1'b0, 1'b0, 10'd7,    32'h0000_FFFF, 1'b0, 16'd0,     13'd0}
  };

  // Calibration phases; the last one restores the reset values with no idling.
  cal_phase_t calibration_phases [7] = '{
    '{20'd0,            20'hFFFFF,         16'd0,                 1'b0, 8'd6,  8'd6},
    '{20'hFFFFF,        20'd20539,         16'hFFFF,              1'b0, 8'd10, 8'd4},
    '{20'd4080,         20'd0,             16'd500,               1'b0, 8'd8,  8'd8},
    '{20'd0,            20'd0,             16'd0,                 1'b1, 8'd5,  8'd12},
    '{20'd1600,         20'd65536,         16'd100,               1'b0, 8'd0,  8'd0},
    '{20'd0,            20'd0,             16'd0,                 1'b1, 8'd3,  8'd3},
    '{FLOOR_OFFSET_RST, INVERSE_SCALE_RST, NEGATIVE_THRESHOLD_RST, 1'b0, 8'd0,  8'd0}
  };

  current_sample_conditioner_top #(
    .WORDS_PER_SAMPLE(GROUP_WORDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Adds one word to the group; on the group's last word returns the reading.
  function automatic bit predict_reading(input in_t word, output out_t reading);
    logic [63:0] total;
    logic [63:0] avg;
    logic [63:0] value;
    logic [63:0] mag;
    logic [15:0] cur;
    reading = '0;
    total = acc_sum + word.conversion;
    if (acc_count + 1 < GROUP_WORDS) begin
      acc_sum   = total[19:0];
      acc_count = acc_count + 4'd1;
      return 1'b0;
    end
    acc_sum   = '0;
    acc_count = '0;
    avg = ((total & 64'hFFFFF) * 64'd16) / GROUP_WORDS;
    if (word.raw_mode) begin
      value = avg;
      mag   = avg >> 4;
    end else begin
      value = (avg > cal_floor) ? avg - cal_floor : 64'd0;
      mag   = (value * cal_scale) >> 20;
    end
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    cur = mag[15:0];
    // Sign filter: only with charge low and the value above the threshold.
    if (!word.charge_pin && value > {cal_threshold, 4'd0}) begin
      if (prev_negative) begin
        cur = 16'd0 - cur;
      end
      prev_negative = (mag != 64'd0);
    end else begin
      prev_negative = 1'b0;
    end
    reading.current  = cur;
    reading.voltage  = VOLT_W'(word.voltage_code) * VOLT_W'(5);
    reading.stamp_ms = word.time_ms;
    return 1'b1;
  endfunction

  // Presents one word, after an optional gap, and waits for its request.
  task automatic send_word(input in_t word, input bit typed, input out_t typed_reading);
    out_t reading;
    if (sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    if (predict_reading(word, reading)) begin
      expected_readings.push_back(typed ? typed_reading : reading);
    end
  endtask

  // Stops new receiver stalls, then waits until every expected reading has
  // arrived, the receiver is ready again and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    receiver_stall_odds = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    while (stall_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three calibration registers, and the unused index when drawn.
  task automatic load_calibration(input cal_phase_t phase);
    logic [CFG_W-1:0] floor_v;
    logic [CFG_W-1:0] scale_v;
    logic [THR_W-1:0] thr_v;
    floor_v = phase.floor_ofs;
    scale_v = phase.scale;
    thr_v   = phase.threshold;
    if (phase.draw) begin
      floor_v = CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 8));
      scale_v = CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 6));
      thr_v   = THR_W'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 10));
    end
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_FLOOR_OFFSET;
    cfg_data     <= floor_v;
    @(posedge clk);
    cfg_index <= CFG_INVERSE_SCALE;
    cfg_data  <= scale_v;
    @(posedge clk);
    cfg_index <= CFG_NEGATIVE_THRESHOLD;
    cfg_data  <= {4'd0, thr_v};
    @(posedge clk);
    if (phase.draw) begin
      cfg_index <= CFG_UNUSED_INDEX;
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_write_en  <= 1'b0;
    cal_floor     = floor_v;
    cal_scale     = scale_v;
    cal_threshold = thr_v;
  endtask

  // Random words shaped per group: full range, clustered, near the floor,
  // or near the floor plus threshold. Only the group's last word carries
  // the chosen mode and charge flag; other words carry noise there.
  task automatic send_random_words(input int count);
    in_t  w;
    out_t unused;
    int   target;
    int   style;
    int   level;
    int   jitter;
    int   floor_int;
    bit   group_raw;
    bit   group_charge;
    unused       = '0;
    style        = 0;
    level        = 0;
    group_raw    = 1'b0;
    group_charge = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (acc_count == 0) begin
        style        = $urandom_range(0, 3);
        level        = $urandom_range(0, 65535);
        group_raw    = ($urandom_range(0, 3) == 0);
        group_charge = ($urandom_range(0, 4) < 2);
      end
      floor_int = int'(cal_floor >> 4);
      jitter    = $urandom_range(0, 63);
      case (style)
        0: target = $urandom_range(0, 65535);
        1: target = level - 32 + jitter;
        2: target = floor_int - 2 + (jitter % 5);
        default: target = floor_int + cal_threshold - 2 + (jitter % 5);
      endcase
      if (target < 0) begin
        target = 0;
      end else if (target > 65535) begin
        target = 65535;
      end
      w.conversion   = target[15:0];
      w.voltage_code = 10'($urandom_range(0, 1023));
      w.time_ms      = $urandom;
      if (acc_count == GROUP_WORDS - 1) begin
        w.raw_mode   = group_raw;
        w.charge_pin = group_charge;
      end else begin
        w.raw_mode   = 1'($urandom_range(0, 1));
        w.charge_pin = 1'($urandom_range(0, 1));
      end
      send_word(w, 1'b0, unused);
    end
  endtask

  // Stimulus: reset, directed groups, then the calibration phases.
  initial begin
    in_t        w;
    out_t       typed_reading;
    group_row_t row;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sender_gap_odds     = 4;
    receiver_stall_odds = 4;
    foreach (directed_groups[g]) begin
      row = directed_groups[g];
      w.conversion   = row.word;
      w.raw_mode     = row.raw;
      w.charge_pin   = row.charge;
      w.voltage_code = row.vcode;
      w.time_ms      = row.stamp;
      typed_reading.current  = row.current;
      typed_reading.voltage  = row.volt;
      typed_reading.stamp_ms = row.stamp;
      repeat (GROUP_WORDS) send_word(w, row.typed, typed_reading);
    end
    foreach (calibration_phases[p]) begin
      settle();
      sender_gap_odds     = int'(calibration_phases[p].gap_odds);
      receiver_stall_odds = int'(calibration_phases[p].stall_odds);
      load_calibration(calibration_phases[p]);
      send_random_words(PHASE_WORDS);
    end
    settle();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: ready drops in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (receiver_stall_odds != 0 &&
                 $urandom_range(1, receiver_stall_odds) == 1) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result request is checked against the oldest expected reading.
  always @(posedge clk) begin : check_readings
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, got current %0d voltage %0d stamp %0d",
                 $time, out_data.current, out_data.voltage, out_data.stamp_ms);
        failed = 1'b1;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.current !== want.current) begin
          $display("%0t: current mismatch, expected %0d, got %0d",
                   $time, want.current, out_data.current);
          failed = 1'b1;
        end
        if (out_data.voltage !== want.voltage) begin
          $display("%0t: voltage mismatch, expected %0d, got %0d",
                   $time, want.voltage, out_data.voltage);
          failed = 1'b1;
        end
        if (out_data.stamp_ms !== want.stamp_ms) begin
          $display("%0t: stamp mismatch, expected %0d, got %0d",
                   $time, want.stamp_ms, out_data.stamp_ms);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
